// ===== rtl/core/prc_pkg.sv =====
// shared types, codes and defaults of the region perimeter counter
package prc_pkg;

   localparam int DEF_MAX_REGIONS = 1024;
   localparam int DEF_MAX_WIDTH   = 4096;
   localparam int LABEL_BITS      = 16;
   localparam int MAX_HEIGHT      = 4096;
   localparam int ROW_BITS        = 12;
   localparam int HEIGHT_BITS     = 13;
   localparam int CSR_ADDR_BITS   = 4;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_PIXEL = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
   localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_REGION_BASE  = 2'd2;
   localparam logic [1:0] REG_REGION_COUNT = 2'd3;

   localparam logic [12:0] RST_GRID_WIDTH   = 13'd256;
   localparam logic [12:0] RST_GRID_HEIGHT  = 13'd256;
   localparam logic [15:0] RST_REGION_BASE  = 16'd0;
   localparam logic [10:0] RST_REGION_COUNT = 11'd1024;

   typedef struct packed {
      logic [1:0]            func;
      logic [LABEL_BITS-1:0] label;
      logic [9:0]            region_index;
   } req_type;

   typedef struct packed {
      logic [31:0] perimeter;
      logic [9:0]  region_echo;
   } rsp_type;

   typedef struct packed {
      logic [12:0]           grid_width;
      logic [12:0]           grid_height;
      logic [LABEL_BITS-1:0] region_base;
      logic [10:0]           region_count;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ABOVE,
      ST_OWN,
      ST_LEFT,
      ST_UP,
      ST_READ
   } state_type;

endpackage

// ===== rtl/core/prc_ram.sv =====
// generic single-write, single-read memory with registered read data
module prc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/prc_csr.sv =====
// configuration register file behind the apb-style port
module prc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [prc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [prc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [prc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output prc_pkg::cfg_type                     cfg
);
   import prc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_sel;
   logic       wr_en;

   assign reg_sel = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_GRID_WIDTH: begin
               cfg_in.grid_width = pwdata[12:0];
            end
            REG_GRID_HEIGHT: begin
               cfg_in.grid_height = pwdata[12:0];
            end
            REG_REGION_BASE: begin
               cfg_in.region_base = pwdata[LABEL_BITS-1:0];
            end
            REG_REGION_COUNT: begin
               cfg_in.region_count = pwdata[10:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_width   <= RST_GRID_WIDTH;
         cfg_ff.grid_height  <= RST_GRID_HEIGHT;
         cfg_ff.region_base  <= RST_REGION_BASE;
         cfg_ff.region_count <= RST_REGION_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GRID_WIDTH:   prdata = CSR_DATA_BITS'(cfg_ff.grid_width);
         REG_GRID_HEIGHT:  prdata = CSR_DATA_BITS'(cfg_ff.grid_height);
         REG_REGION_BASE:  prdata = CSR_DATA_BITS'(cfg_ff.region_base);
         REG_REGION_COUNT: prdata = CSR_DATA_BITS'(cfg_ff.region_count);
         default:          prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

// ===== rtl/core/region_perimeter_counter_top.sv =====
// top level of the region perimeter counter
// Takes a label raster in row order and keeps a 32-bit perimeter count per region in one
// count memory of MAX_REGIONS words; the labels of the row above sit in a line memory of
// MAX_WIDTH words. A pixel word does one line-memory read, then three read-modify-write
// passes (own, left and upper region) through the single write port of the count memory,
// with the last write forwarded to the next read. A read word loads the result register
// from the count memory, held while the result side stalls. A clear word, and reset
// itself, sweep all MAX_REGIONS entries (1024 by default) of the count memory one entry
// a cycle, during which no word is taken; configuration writes are taken at any time.
module region_perimeter_counter_top #(
   parameter int MAX_REGIONS = prc_pkg::DEF_MAX_REGIONS,
   parameter int MAX_WIDTH   = prc_pkg::DEF_MAX_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  prc_pkg::req_type                  req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output prc_pkg::rsp_type                  rsp_word,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [prc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [prc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [prc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import prc_pkg::*;

   localparam int RW       = $clog2(MAX_REGIONS);
   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int WB       = $clog2(MAX_WIDTH + 1);
   localparam int CNT_BITS = $clog2(MAX_REGIONS + 1);
   localparam int RI_BITS  = 17;

   function automatic logic [RW:0] region_of(input logic [LABEL_BITS-1:0] lab,
                                             input logic [LABEL_BITS-1:0] base,
                                             input logic [CNT_BITS-1:0]   cnt);
      logic [LABEL_BITS-1:0] diff;
      logic                  hit;
      diff = lab - base;
      hit  = (lab >= base) && (32'(diff) < 32'(cnt));
      return {hit, diff[RW-1:0]};
   endfunction

   cfg_type   cfg;
   state_type state_ff, state_in;

   logic [RW-1:0]         clr_ff, clr_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [LABEL_BITS-1:0] left_ff, left_in;

   logic [CW-1:0]         pix_col_ff;
   logic [LABEL_BITS-1:0] pix_lab_ff;
   logic                  first_col_ff, first_row_ff, last_col_ff, last_row_ff;
   logic                  left_diff_ff;
   logic [RW:0]           own_map_ff, left_map_ff, above_map_ff;
   logic                  above_diff_ff;
   logic [2:0]            own_amt_ff;

   logic [9:0]            echo_ff;
   logic                  rd_zero_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;

   logic                  byp_ff;
   logic [31:0]           byp_data_ff;

   logic                  req_acc, last_col, last_row, left_diff, above_diff, rsp_load;
   logic                  rd_in_range;
   logic [WB-1:0]         w_eff, col_plus;
   logic [HEIGHT_BITS-1:0] h_eff, row_plus;
   logic [CNT_BITS-1:0]   cnt_eff;
   logic [RI_BITS-1:0]    ridx_ext;
   logic [2:0]            own_amt;

   logic                  cnt_we, cnt_re;
   logic [RW-1:0]         cnt_waddr, cnt_raddr;
   logic [31:0]           cnt_wdata, cnt_rdata, cnt_data;
   logic                  line_re, line_we;
   logic [LABEL_BITS-1:0] line_rdata;

   prc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   prc_ram #(.WIDTH(32), .DEPTH(MAX_REGIONS)) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .re    (cnt_re),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   prc_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock (clock),
      .we    (line_we),
      .waddr (pix_col_ff),
      .wdata (pix_lab_ff),
      .re    (line_re),
      .raddr (col_ff),
      .rdata (line_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;

   // effective geometry and region range
   always_comb begin
      if (cfg.grid_width == '0) begin
         w_eff = WB'(1);
      end else if (32'(cfg.grid_width) > MAX_WIDTH) begin
         w_eff = WB'(MAX_WIDTH);
      end else begin
         w_eff = WB'(cfg.grid_width);
      end
      if (cfg.grid_height == '0) begin
         h_eff = HEIGHT_BITS'(1);
      end else if (32'(cfg.grid_height) > MAX_HEIGHT) begin
         h_eff = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = cfg.grid_height;
      end
      if (32'(cfg.region_count) > MAX_REGIONS) begin
         cnt_eff = CNT_BITS'(MAX_REGIONS);
      end else begin
         cnt_eff = CNT_BITS'(cfg.region_count);
      end
   end

   assign col_plus    = WB'(col_ff) + WB'(1);
   assign row_plus    = HEIGHT_BITS'(row_ff) + HEIGHT_BITS'(1);
   assign last_col    = (col_plus >= w_eff);
   assign last_row    = (row_plus >= h_eff);
   assign left_diff   = (col_ff != '0) && (left_ff != req_word.label);
   assign ridx_ext    = RI_BITS'(req_word.region_index);
   assign rd_in_range = (32'(ridx_ext) < MAX_REGIONS);

   assign above_diff = !first_row_ff && (line_rdata != pix_lab_ff);
   assign own_amt    = 3'(first_col_ff || left_diff_ff) + 3'(first_row_ff || above_diff)
                     + 3'(last_col_ff) + 3'(last_row_ff);

   assign cnt_data = byp_ff ? byp_data_ff : cnt_rdata;
   assign rsp_load = (state_ff == ST_READ) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == RW'(MAX_REGIONS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               case (req_word.func)
                  FUNC_CLEAR: state_in = ST_CLEAR;
                  FUNC_PIXEL: state_in = ST_ABOVE;
                  FUNC_READ:  state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ABOVE: state_in = ST_OWN;
         ST_OWN:   state_in = ST_LEFT;
         ST_LEFT:  state_in = ST_UP;
         ST_UP:    state_in = ST_IDLE;
         ST_READ: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = own_map_ff[RW-1:0];
      cnt_wdata = '0;
      cnt_re    = 1'b0;
      cnt_raddr = own_map_ff[RW-1:0];
      line_re   = 1'b0;
      line_we   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
         end
         ST_IDLE: begin
            line_re   = req_acc && (req_word.func == FUNC_PIXEL);
            cnt_re    = req_acc && (req_word.func == FUNC_READ) && rd_in_range;
            cnt_raddr = ridx_ext[RW-1:0];
         end
         ST_ABOVE: begin
            line_we = 1'b1;
            cnt_re  = 1'b1;
         end
         ST_OWN: begin
            cnt_we    = own_map_ff[RW];
            cnt_wdata = cnt_data + 32'(own_amt_ff);
            cnt_re    = 1'b1;
            cnt_raddr = left_map_ff[RW-1:0];
         end
         ST_LEFT: begin
            cnt_we    = left_diff_ff && left_map_ff[RW];
            cnt_waddr = left_map_ff[RW-1:0];
            cnt_wdata = cnt_data + 32'd1;
            cnt_re    = 1'b1;
            cnt_raddr = above_map_ff[RW-1:0];
         end
         ST_UP: begin
            cnt_we    = above_diff_ff && above_map_ff[RW];
            cnt_waddr = above_map_ff[RW-1:0];
            cnt_wdata = cnt_data + 32'd1;
         end
         default: begin
            cnt_we = 1'b0;
         end
      endcase
   end

   // raster position and clear sweep
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      clr_in  = '0;
      if (state_ff == ST_CLEAR && clr_ff != RW'(MAX_REGIONS - 1)) begin
         clr_in = clr_ff + RW'(1);
      end
      if (req_acc && req_word.func == FUNC_CLEAR) begin
         col_in  = '0;
         row_in  = '0;
         left_in = '0;
      end else if (req_acc && req_word.func == FUNC_PIXEL) begin
         left_in = req_word.label;
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_plus[ROW_BITS-1:0];
         end else begin
            col_in = col_plus[CW-1:0];
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_re) begin
            byp_ff <= cnt_we && (cnt_waddr == cnt_raddr);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cnt_re) begin
         byp_data_ff <= cnt_wdata;
      end
      if (req_acc) begin
         pix_col_ff   <= col_ff;
         pix_lab_ff   <= req_word.label;
         first_col_ff <= (col_ff == '0);
         first_row_ff <= (row_ff == '0);
         last_col_ff  <= last_col;
         last_row_ff  <= last_row;
         left_diff_ff <= left_diff;
         own_map_ff   <= region_of(req_word.label, cfg.region_base, cnt_eff);
         left_map_ff  <= region_of(left_ff, cfg.region_base, cnt_eff);
         echo_ff      <= req_word.region_index;
         rd_zero_ff   <= !rd_in_range;
      end
      if (state_ff == ST_ABOVE) begin
         above_map_ff  <= region_of(line_rdata, cfg.region_base, cnt_eff);
         above_diff_ff <= above_diff;
         own_amt_ff    <= own_amt;
      end
      if (rsp_load) begin
         rsp_ff.perimeter   <= rd_zero_ff ? '0 : cnt_data;
         rsp_ff.region_echo <= echo_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_no_count_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_READ) |-> !cnt_we)
      else $error("count memory written outside a pixel or clear pass");

   a_pixel_starts_above: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_word.func == FUNC_PIXEL) |=> (state_ff == ST_ABOVE))
      else $error("pixel word did not start with the line read");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < MAX_WIDTH)
      else $error("column position beyond line memory");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_READ))
      else $error("result raised without a read word");

endmodule
